### rtl/core/psh_pkg.sv
// Package for the PC sample histogram profiler: sizes, codes and shared types.
// No dependencies.
package psh_pkg;

    localparam int NUM_REGIONS = 8;
    localparam int BIN_BYTES   = 4;
    localparam int HIST_DEPTH  = 4096;
    localparam int SLOT_W      = 3;
    localparam int BIN_W       = $clog2(HIST_DEPTH);
    localparam int SHIFT_W     = $clog2(BIN_BYTES);
    localparam int PHASE_W     = 17;
    localparam int QDEPTH      = 2;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] CFG_RUNNING = 2'd0;
    localparam logic [1:0] CFG_RATE    = 2'd1;
    localparam logic [1:0] CFG_TICKS   = 2'd2;
    localparam logic [1:0] CFG_BYPASS  = 2'd3;

    localparam logic [2:0] OUT_IGNORED   = 3'd0;
    localparam logic [2:0] OUT_COUNTED   = 3'd1;
    localparam logic [2:0] OUT_SATURATED = 3'd2;
    localparam logic [2:0] OUT_UNMAPPED  = 3'd3;
    localparam logic [2:0] OUT_WRITTEN   = 3'd4;
    localparam logic [2:0] OUT_READ      = 3'd5;

    typedef enum logic [1:0]
    {
        CMD_NONE,
        CMD_SAMPLE,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    typedef struct packed
    {
        cmd_t              cmd;
        logic              hit;
        logic              kernel;
        logic [BIN_W-1:0]  bin;
    } job_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_OUT
    } back_state_t;

endpackage

### rtl/core/psh_front.sv
// Front end: divider, region slots and bin lookup; emits one job per beat.
// Depends on psh_pkg.
module psh_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [31:0]          pc,
    input  logic [2:0]           region_slot,
    input  logic [31:0]          region_low,
    input  logic [31:0]          region_high,
    input  logic [31:0]          hist_low,
    input  logic [11:0]          bin_offset,
    input  logic                 region_is_kernel,
    input  logic [11:0]          bin_address,
    output logic                 job_valid,
    output psh_pkg::job_t        job,
    input  logic                 job_full
);
    import psh_pkg::*;

    logic                running_reg;
    logic [15:0]         rate_reg;
    logic [15:0]         ticks_reg;
    logic                bypass_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [31:0]         low_reg   [NUM_REGIONS];
    logic [31:0]         high_reg  [NUM_REGIONS];
    logic [31:0]         hlow_reg  [NUM_REGIONS];
    logic [BIN_W-1:0]    off_reg   [NUM_REGIONS];
    logic                kern_reg  [NUM_REGIONS];

    logic                accept;
    logic                sample;
    logic [15:0]         modulus;
    logic [15:0]         rate;
    logic [PHASE_W-1:0]  sum;
    logic                hit;
    logic [SLOT_W-1:0]   hit_slot;
    logic [31:0]         delta;
    job_t                job_w;

    assign in_stall = job_full;
    assign accept   = in_valid && !job_full;

    always_comb
    begin
        modulus = (ticks_reg == 16'd0) ? 16'd1 : ticks_reg;
        rate    = (rate_reg < modulus) ? rate_reg : modulus;
        sum     = phase_reg + PHASE_W'(rate);
        sample  = 1'b0;
        phase_next = phase_reg;
        if (running_reg)
        begin
            if (bypass_reg)
            begin
                sample = 1'b1;
            end
            else if (sum >= PHASE_W'(modulus))
            begin
                sample = 1'b1;
                phase_next = sum - PHASE_W'(modulus);
            end
            else
            begin
                phase_next = sum;
            end
        end
    end

    always_comb
    begin
        hit = 1'b0;
        hit_slot = '0;
        for (int s = NUM_REGIONS - 1; s >= 0; s--)
        begin
            if (pc >= low_reg[s] && pc < high_reg[s])
            begin
                hit = 1'b1;
                hit_slot = SLOT_W'(s);
            end
        end
        delta = pc - hlow_reg[hit_slot];
    end

    always_comb
    begin
        job_w.cmd    = CMD_NONE;
        job_w.hit    = hit;
        job_w.kernel = kern_reg[hit_slot];
        job_w.bin    = BIN_W'(delta >> SHIFT_W) + off_reg[hit_slot];
        case (action)
            ACT_TICK:
            begin
                if (sample)
                begin
                    job_w.cmd = CMD_SAMPLE;
                end
            end
            ACT_WRITE:
            begin
                job_w.cmd = CMD_WRITE;
            end
            ACT_READ:
            begin
                job_w.cmd = CMD_READ;
                job_w.bin = bin_address;
            end
            default:
            begin
                job_w.cmd = CMD_NONE;
            end
        endcase
    end

    assign job_valid = accept;
    assign job       = job_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            rate_reg    <= 16'd100;
            ticks_reg   <= 16'd1000;
            bypass_reg  <= 1'b0;
            phase_reg   <= '0;
            for (int s = 0; s < NUM_REGIONS; s++)
            begin
                low_reg[s]  <= '0;
                high_reg[s] <= '0;
                hlow_reg[s] <= '0;
                off_reg[s]  <= '0;
                kern_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RUNNING: running_reg <= cfg_data[0];
                    CFG_RATE:    rate_reg    <= cfg_data;
                    CFG_TICKS:   ticks_reg   <= cfg_data;
                    CFG_BYPASS:  bypass_reg  <= cfg_data[0];
                    default:     running_reg <= running_reg;
                endcase
            end
            if (accept && action == ACT_TICK)
            begin
                phase_reg <= phase_next;
            end
            if (accept && action == ACT_WRITE)
            begin
                low_reg[region_slot]  <= region_low;
                high_reg[region_slot] <= region_high;
                hlow_reg[region_slot] <= hist_low;
                off_reg[region_slot]  <= bin_offset;
                kern_reg[region_slot] <= region_is_kernel;
            end
        end
    end

endmodule

### rtl/core/psh_queue.sv
// Two-entry job queue between front and back.
// Depends on psh_pkg.
module psh_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  psh_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output psh_pkg::job_t  head
);
    import psh_pkg::*;

    job_t        mem_reg [QDEPTH];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;

    assign full      = (cnt_reg == 2'(QDEPTH));
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) full |-> !push;
    endproperty
    assert property (p_no_overflow) else $error("queue overflow");

    property p_no_underflow;
        @(posedge clk) disable iff (!rst_n) !not_empty |-> !pop;
    endproperty
    assert property (p_no_underflow) else $error("queue underflow");

    property p_count_step;
        @(posedge clk) disable iff (!rst_n) (push && !pop) |=> not_empty;
    endproperty
    assert property (p_count_step) else $error("queue count lost a push");

endmodule

### rtl/core/psh_back.sv
// Back end: histogram memory with clearing pass, totals, result register.
// Depends on psh_pkg.
module psh_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_ready,
    input  psh_pkg::job_t  job,
    output logic           job_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     outcome,
    output logic [31:0]    bin_value,
    output logic [31:0]    total_samples,
    output logic [31:0]    kernel_samples,
    output logic [31:0]    application_samples,
    output logic [31:0]    unmapped_samples,
    output logic [31:0]    saturated_samples
);
    import psh_pkg::*;

    logic [31:0]       hist_mem [HIST_DEPTH];
    logic [31:0]       rd_reg;
    back_state_t       state_reg;
    back_state_t       state_next;
    logic [BIN_W:0]    clr_reg;
    job_t              job_reg;
    logic [2:0]        outcome_reg;
    logic [31:0]       value_reg;
    logic [31:0]       tot_reg;
    logic [31:0]       kern_reg;
    logic [31:0]       app_reg;
    logic [31:0]       unm_reg;
    logic [31:0]       sat_reg;
    logic              mem_we;
    logic [BIN_W-1:0]  mem_wa;
    logic [31:0]       mem_wd;
    logic              take;
    logic              full_bin;

    assign full_bin = (rd_reg == 32'hFFFF_FFFF);

    always_comb
    begin
        state_next = state_reg;
        take   = 1'b0;
        mem_we = 1'b0;
        mem_wa = job_reg.bin;
        mem_wd = rd_reg + 32'd1;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg[BIN_W-1:0];
                mem_wd = '0;
                if (clr_reg == (BIN_W+1)'(HIST_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (job_ready)
                begin
                    take = 1'b1;
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                mem_we = (job_reg.cmd == CMD_SAMPLE) && job_reg.hit && !full_bin;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign job_pop = take;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_wa] <= mem_wd;
        end
        rd_reg <= hist_mem[take ? job.bin : job_reg.bin];
        if (take)
        begin
            job_reg <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            outcome_reg <= OUT_IGNORED;
            value_reg   <= '0;
            tot_reg     <= '0;
            kern_reg    <= '0;
            app_reg     <= '0;
            unm_reg     <= '0;
            sat_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_RMW)
            begin
                value_reg <= '0;
                case (job_reg.cmd)
                    CMD_SAMPLE:
                    begin
                        tot_reg <= tot_reg + 32'd1;
                        if (!job_reg.hit)
                        begin
                            outcome_reg <= OUT_UNMAPPED;
                            unm_reg     <= unm_reg + 32'd1;
                        end
                        else
                        begin
                            if (job_reg.kernel)
                            begin
                                kern_reg <= kern_reg + 32'd1;
                            end
                            else
                            begin
                                app_reg <= app_reg + 32'd1;
                            end
                            if (full_bin)
                            begin
                                outcome_reg <= OUT_SATURATED;
                                value_reg   <= rd_reg;
                                sat_reg     <= sat_reg + 32'd1;
                            end
                            else
                            begin
                                outcome_reg <= OUT_COUNTED;
                                value_reg   <= rd_reg + 32'd1;
                            end
                        end
                    end
                    CMD_WRITE: outcome_reg <= OUT_WRITTEN;
                    CMD_READ:
                    begin
                        outcome_reg <= OUT_READ;
                        value_reg   <= rd_reg;
                    end
                    default: outcome_reg <= OUT_IGNORED;
                endcase
            end
        end
    end

    assign out_valid           = (state_reg == ST_OUT);
    assign outcome             = outcome_reg;
    assign bin_value           = value_reg;
    assign total_samples       = tot_reg;
    assign kernel_samples      = kern_reg;
    assign application_samples = app_reg;
    assign unmapped_samples    = unm_reg;
    assign saturated_samples   = sat_reg;

    property p_no_pop_while_clearing;
        @(posedge clk) disable iff (!rst_n) (state_reg == ST_CLEAR) |-> !job_pop;
    endproperty
    assert property (p_no_pop_while_clearing) else $error("job taken during clear");

    property p_rmw_then_out;
        @(posedge clk) disable iff (!rst_n) (state_reg == ST_RMW) |=> out_valid;
    endproperty
    assert property (p_rmw_then_out) else $error("result not presented");

    property p_sat_counts;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_RMW && job_reg.cmd == CMD_SAMPLE && job_reg.hit && full_bin)
            |=> (sat_reg == $past(sat_reg) + 32'd1);
    endproperty
    assert property (p_sat_counts) else $error("saturation not counted");

endmodule

### rtl/core/pc_sample_histogram_profiler.sv
// PC sample histogram profiler top level: front, job queue, back.
// The back end takes one job at a time through the histogram read-modify-write
// and result states, and takes no new job until the result beat is out; the
// front takes beats while the two-entry queue has room.
// Reset: after rst_n rises the back clears 4096 bins, one per cycle, before
// the first result; input beats queue up meanwhile until the queue is full.
module pc_sample_histogram_profiler
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   action,
    input  logic [31:0]  pc,
    input  logic [2:0]   region_slot,
    input  logic [31:0]  region_low,
    input  logic [31:0]  region_high,
    input  logic [31:0]  hist_low,
    input  logic [11:0]  bin_offset,
    input  logic         region_is_kernel,
    input  logic [11:0]  bin_address,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   outcome,
    output logic [31:0]  bin_value,
    output logic [31:0]  total_samples,
    output logic [31:0]  kernel_samples,
    output logic [31:0]  application_samples,
    output logic [31:0]  unmapped_samples,
    output logic [31:0]  saturated_samples
);
    import psh_pkg::*;

    logic  push;
    job_t  push_job;
    logic  q_full;
    logic  pop;
    logic  q_ne;
    job_t  head;

    psh_front u_front
    (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .action, .pc, .region_slot, .region_low,
        .region_high, .hist_low, .bin_offset, .region_is_kernel, .bin_address,
        .job_valid(push), .job(push_job), .job_full(q_full)
    );

    psh_queue u_queue
    (
        .clk, .rst_n, .push, .push_job, .full(q_full),
        .pop, .not_empty(q_ne), .head
    );

    psh_back u_back
    (
        .clk, .rst_n, .job_ready(q_ne), .job(head), .job_pop(pop),
        .out_valid, .out_stall, .outcome, .bin_value, .total_samples,
        .kernel_samples, .application_samples, .unmapped_samples,
        .saturated_samples
    );

endmodule
